@@ rtl/core/utf8_stream_validator_top_assert.svh @@
// Assertion macros shared by the UTF-8 stream validator RTL.
// Included by modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef UTF8_STREAM_VALIDATOR_TOP_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_TOP_ASSERT_SVH

// Check that is disabled while reset is asserted.
`define U8SV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds during reset.
`define U8SV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/utf8sv_pkg.sv @@
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; imported by utf8sv_step, utf8_stream_validator_top and the bench modules.
`timescale 1ns / 1ps

package utf8sv_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int ACC_BITS = 21;

	typedef enum logic [2:0] {
		FK_OK       = 3'd0,
		FK_NUL      = 3'd1,
		FK_LEAD     = 3'd2,
		FK_CONT     = 3'd3,
		FK_TRUNC    = 3'd4,
		FK_OVERLONG = 3'd5,
		FK_SURR     = 3'd6,
		FK_ABOVE    = 3'd7
	} fault_kind_t;

	localparam logic [ACC_BITS-1:0] CP_MIN_2B   = 21'h000080;
	localparam logic [ACC_BITS-1:0] CP_MIN_3B   = 21'h000800;
	localparam logic [ACC_BITS-1:0] CP_MIN_4B   = 21'h010000;
	localparam logic [ACC_BITS-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [ACC_BITS-1:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [ACC_BITS-1:0] CP_SURR_HI  = 21'h00DFFF;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [1:0]          pending;
		logic [1:0]          seq_len;
		logic [ACC_BITS-1:0] acc;
		fault_kind_t         fault;
	} dec_state_t;

	localparam dec_state_t DEC_STATE_RESET = '{
		pending: 2'd0,
		seq_len: 2'd0,
		acc:     '0,
		fault:   FK_OK
	};

endpackage

@@ rtl/core/utf8sv_step.sv @@
// Per-byte decode step: next decoder state, positions and verdict for one byte.
// Purely combinational; depends on utf8sv_pkg.
`timescale 1ns / 1ps

module utf8sv_step
	import utf8sv_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  dec_state_t             cur_state,
	input  logic [OFFSET_BITS-1:0] cur_byte_pos,
	input  logic [OFFSET_BITS-1:0] cur_fault_pos,
	input  logic [7:0]             byte_in,
	input  logic                   end_of_string,
	output dec_state_t             nxt_state,
	output logic [OFFSET_BITS-1:0] nxt_byte_pos,
	output logic [OFFSET_BITS-1:0] nxt_fault_pos,
	output logic                   res_is_valid,
	output fault_kind_t            res_kind,
	output logic [OFFSET_BITS-1:0] res_offset
);

	dec_state_t             upd;
	fault_kind_t            raise;
	logic [ACC_BITS-1:0]    cp;
	logic [OFFSET_BITS-1:0] fpos;

	always_comb begin
		upd   = cur_state;
		raise = FK_OK;
		cp    = {cur_state.acc[ACC_BITS-7:0], byte_in[5:0]};
		if (cur_state.fault == FK_OK) begin
			if (cur_state.pending == 2'd0) begin
				if (byte_in == 8'h00) begin
					raise = FK_NUL;
				end else if (!byte_in[7]) begin
					upd.pending = 2'd0;
				end else if (byte_in[7:5] == 3'b110) begin
					upd.acc = {16'd0, byte_in[4:0]};
					// A lead of 0xC0 is overlong on its own; 0xC1 is caught at completion.
					if (byte_in[4:0] == 5'd0) begin
						raise = FK_OVERLONG;
					end else begin
						upd.pending = 2'd1;
						upd.seq_len = 2'd1;
					end
				end else if (byte_in[7:4] == 4'b1110) begin
					upd.acc     = {17'd0, byte_in[3:0]};
					upd.pending = 2'd2;
					upd.seq_len = 2'd2;
				end else if (byte_in[7:3] == 5'b11110) begin
					upd.acc     = {18'd0, byte_in[2:0]};
					upd.pending = 2'd3;
					upd.seq_len = 2'd3;
				end else begin
					raise = FK_LEAD;
				end
			end else if (byte_in[7:6] != 2'b10) begin
				raise = FK_CONT;
			end else begin
				upd.acc     = cp;
				upd.pending = cur_state.pending - 2'd1;
				if (upd.pending == 2'd0) begin
					if ((cur_state.seq_len == 2'd1 && cp < CP_MIN_2B) ||
					    (cur_state.seq_len == 2'd2 && cp < CP_MIN_3B) ||
					    (cur_state.seq_len == 2'd3 && cp < CP_MIN_4B)) begin
						raise = FK_OVERLONG;
					end else if (cp > CP_MAX) begin
						raise = FK_ABOVE;
					end else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
						raise = FK_SURR;
					end
				end
			end
			// A sequence still open on the last byte is cut off.
			if (end_of_string && raise == FK_OK && upd.pending != 2'd0) begin
				raise = FK_TRUNC;
			end
		end

		fpos = cur_fault_pos;
		if (raise != FK_OK) begin
			upd.fault = raise;
			fpos      = cur_byte_pos;
		end

		res_is_valid = (upd.fault == FK_OK);
		res_kind     = upd.fault;
		res_offset   = res_is_valid ? '0 : fpos;

		if (end_of_string) begin
			nxt_state     = DEC_STATE_RESET;
			nxt_byte_pos  = '0;
			nxt_fault_pos = '0;
		end else begin
			nxt_state     = upd;
			nxt_fault_pos = fpos;
			nxt_byte_pos  = (cur_byte_pos == {OFFSET_BITS{1'b1}}) ? cur_byte_pos
			                                                     : cur_byte_pos + 1'b1;
		end
	end

endmodule

@@ rtl/core/utf8_stream_validator_top.sv @@
// Top level of the UTF-8 stream validator: input register, decoder state, result register.
// Depends on utf8sv_pkg, utf8sv_step and utf8_stream_validator_top_assert.svh.
//
// Usage: a string enters one byte per request on the input channel
// (in_valid, in_stall, byte_in, end_of_string), with end_of_string set on
// its final byte. Exactly one result leaves on the output channel
// (out_valid, out_stall, is_valid, fault_kind, fault_offset) for each
// string, after its final byte. Bytes that follow the first fault are
// consumed and ignored. An empty string sends no bytes and gets no result.
// A final byte passes from the input register into the result register.
// Throughput: one byte per cycle while in_stall is low, set by the single
// decode step between the input register and the state and result registers.
// When the receiver stalls, the result register holds its request; a
// mid-string byte still advances, and a final byte waits in the input
// register, which then raises in_stall until the result is taken.
// Reset clears the decoder state, byte counter and both valid flags, so
// the first byte after reset begins a new string.
// fault_offset saturates at 2^OFFSET_BITS - 1.
`timescale 1ns / 1ps

module utf8_stream_validator_top
	import utf8sv_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             byte_in,
	input  logic                   end_of_string,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_valid,
	output logic [2:0]             fault_kind,
	output logic [OFFSET_BITS-1:0] fault_offset
);

`include "utf8_stream_validator_top_assert.svh"

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eos_s1;

	dec_state_t             state_q;
	logic [OFFSET_BITS-1:0] byte_pos_q;
	logic [OFFSET_BITS-1:0] fault_pos_q;

	logic                   out_valid_q;
	logic                   is_valid_q;
	fault_kind_t            fault_kind_q;
	logic [OFFSET_BITS-1:0] fault_offset_q;

	dec_state_t             nxt_state;
	logic [OFFSET_BITS-1:0] nxt_byte_pos;
	logic [OFFSET_BITS-1:0] nxt_fault_pos;
	logic                   res_is_valid;
	fault_kind_t            res_kind;
	logic [OFFSET_BITS-1:0] res_offset;

	logic                   out_free;
	logic                   adv_s1;
	logic                   in_take;

	utf8sv_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.cur_state    (state_q),
		.cur_byte_pos (byte_pos_q),
		.cur_fault_pos(fault_pos_q),
		.byte_in      (byte_s1),
		.end_of_string(eos_s1),
		.nxt_state    (nxt_state),
		.nxt_byte_pos (nxt_byte_pos),
		.nxt_fault_pos(nxt_fault_pos),
		.res_is_valid (res_is_valid),
		.res_kind     (res_kind),
		.res_offset   (res_offset)
	);

	assign out_free = !out_valid_q || !out_stall;
	// Only a final byte needs room in the result register.
	assign adv_s1   = valid_s1 && (!eos_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DEC_STATE_RESET;
			byte_pos_q  <= '0;
			fault_pos_q <= '0;
		end else if (adv_s1) begin
			state_q     <= nxt_state;
			byte_pos_q  <= nxt_byte_pos;
			fault_pos_q <= nxt_fault_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && eos_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eos_s1) begin
			is_valid_q     <= res_is_valid;
			fault_kind_q   <= res_kind;
			fault_offset_q <= res_offset;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_valid     = is_valid_q;
	assign fault_kind   = fault_kind_q;
	assign fault_offset = fault_offset_q;

	`U8SV_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result valid during reset")
	`U8SV_ASSERT(a_verdict_matches_kind, out_valid |-> (is_valid == (fault_kind == FK_OK)), "verdict disagrees with fault kind")
	`U8SV_ASSERT(a_valid_offset_zero, (out_valid && is_valid) |-> (fault_offset == '0), "nonzero offset on a valid string")
	`U8SV_ASSERT(a_final_byte_gives_result, (adv_s1 && eos_s1) |=> out_valid, "final byte did not produce a result")
	`U8SV_ASSERT(a_cleared_after_final, (adv_s1 && eos_s1) |=> (state_q == DEC_STATE_RESET && byte_pos_q == '0), "decoder not cleared after final byte")
	`U8SV_ASSERT(a_pending_within_len, state_q.pending <= state_q.seq_len, "pending count exceeds sequence length")

endmodule

@@ bench/utf8_verdict_checker.sv @@
// Watches both channels of the UTF-8 stream validator, predicts each verdict and compares.
// Depends on utf8sv_pkg for the fault kinds and code point limits.
`timescale 1ns / 1ps

module utf8_verdict_checker
	import utf8sv_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [7:0]             byte_in,
	input  logic                   end_of_string,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   is_valid,
	input  logic [2:0]             fault_kind,
	input  logic [OFFSET_BITS-1:0] fault_offset,
	output int                     fail_count,
	output int                     outstanding
);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	typedef struct packed {
		logic                   ok;
		fault_kind_t            kind;
		logic [OFFSET_BITS-1:0] offset;
	} verdict_t;

	verdict_t verdict_q[$];

	logic [1:0]             cont_left;
	logic [1:0]             seq_len;
	logic [ACC_BITS-1:0]    code_acc;
	fault_kind_t            first_fault;
	logic [OFFSET_BITS-1:0] byte_pos;
	logic [OFFSET_BITS-1:0] fault_pos;

	task automatic clear_string();
		cont_left = 2'd0;
		seq_len = 2'd0;
		code_acc = '0;
		first_fault = FK_OK;
		byte_pos = '0;
		fault_pos = '0;
	endtask

	task automatic note_fault(input fault_kind_t kind);
		if (first_fault == FK_OK) begin
			first_fault = kind;
			fault_pos = byte_pos;
		end
	endtask

	task automatic log_failure(input string msg);
		if (fail_count < 10)
			$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Advances the decoder by one byte; a final byte queues the verdict of the string.
	task automatic decode_byte(input logic [7:0] b, input logic last);
		verdict_t v;
		if (first_fault == FK_OK) begin
			if (cont_left == 2'd0) begin
				if (b == 8'h00) begin
					note_fault(FK_NUL);
				end else if (b[7] == 1'b0) begin
				end else if (b[7:5] == 3'b110) begin
					code_acc = {16'd0, b[4:0]};
					if (b[4:0] == 5'd0) begin
						note_fault(FK_OVERLONG);
					end else begin
						cont_left = 2'd1;
						seq_len = 2'd1;
					end
				end else if (b[7:4] == 4'b1110) begin
					code_acc = {17'd0, b[3:0]};
					cont_left = 2'd2;
					seq_len = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					code_acc = {18'd0, b[2:0]};
					cont_left = 2'd3;
					seq_len = 2'd3;
				end else begin
					note_fault(FK_LEAD);
				end
			end else if (b[7:6] != 2'b10) begin
				note_fault(FK_CONT);
			end else begin
				code_acc = {code_acc[ACC_BITS-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					if ((seq_len == 2'd1 && code_acc < CP_MIN_2B) ||
							(seq_len == 2'd2 && code_acc < CP_MIN_3B) ||
							(seq_len == 2'd3 && code_acc < CP_MIN_4B))
						note_fault(FK_OVERLONG);
					else if (code_acc > CP_MAX)
						note_fault(FK_ABOVE);
					else if (code_acc >= CP_SURR_LO && code_acc <= CP_SURR_HI)
						note_fault(FK_SURR);
				end
			end
			if (last && first_fault == FK_OK && cont_left != 2'd0)
				note_fault(FK_TRUNC);
		end
		if (!last) begin
			if (byte_pos != POS_MAX)
				byte_pos = byte_pos + 1'b1;
		end else begin
			v.ok = (first_fault == FK_OK);
			v.kind = first_fault;
			v.offset = v.ok ? '0 : fault_pos;
			verdict_q = {verdict_q, v};
			clear_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			clear_string();
			verdict_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					log_failure($sformatf("unexpected verdict: valid=%0b kind=%0d offset=%0d",
						is_valid, fault_kind, fault_offset));
				end else begin
					want = verdict_q.pop_front();
					if (is_valid !== want.ok || fault_kind !== want.kind ||
							fault_offset !== want.offset)
						log_failure($sformatf(
							{"verdict mismatch: expected valid=%0b kind=%0d offset=%0d,",
							" got valid=%0b kind=%0d offset=%0d"},
							want.ok, want.kind, want.offset, is_valid, fault_kind, fault_offset));
				end
			end
			if (in_valid && !in_stall)
				decode_byte(byte_in, end_of_string);
			outstanding <= verdict_q.size();
		end
	end

endmodule

@@ bench/tb_utf8_stream_validator_top.sv @@
// Testbench top for the UTF-8 stream validator: clock, reset, string stimulus and verdict.
// Depends on utf8sv_pkg, utf8_stream_validator_top and utf8_verdict_checker.
`timescale 1ns / 1ps

module tb_utf8_stream_validator_top;
	import utf8sv_pkg::*;

	localparam int OFFSET_BITS = OFFSET_BITS_DEF;
	localparam int RANDOM_BYTES = 800;

	typedef logic [7:0] octet_t;

	typedef enum int {
		CH_VALID,
		CH_NUL,
		CH_LEAD,
		CH_CONT,
		CH_OVERLONG,
		CH_SURR,
		CH_ABOVE,
		CH_TRUNC
	} char_kind_t;

	logic                   clk;
	logic                   arst_n = 1'b1;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             byte_in = 8'h00;
	logic                   end_of_string = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   is_valid;
	logic [2:0]             fault_kind;
	logic [OFFSET_BITS-1:0] fault_offset;
	int                     fail_count;
	int                     outstanding;

	int     idle_pct = 19;
	int     stall_pct = 19;
	octet_t text[$];

	utf8_stream_validator_top #(.OFFSET_BITS(OFFSET_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_valid(is_valid),
		.fault_kind(fault_kind),
		.fault_offset(fault_offset)
	);

	utf8_verdict_checker #(.OFFSET_BITS(OFFSET_BITS)) verdict_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_valid(is_valid),
		.fault_kind(fault_kind),
		.fault_offset(fault_offset),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_byte(input octet_t b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		end_of_string <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Sends a short string packed first byte highest.
	task automatic send_packed(input logic [31:0] bytes, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_byte(bytes[8*i +: 8], i == 0);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	// Holds the sender off until every queued verdict has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic append_octet(input octet_t b);
		text = {text, b};
	endtask

	function automatic int valid_code_point(input int n);
		int cp;
		case (n)
			1: cp = $urandom_range(1, 'h7F);
			2: cp = $urandom_range('h80, 'h7FF);
			3: begin
				cp = $urandom_range('h800, 'hFFFF);
				if (cp >= 'hD800 && cp <= 'hDFFF)
					cp = cp ^ 'h1000;
			end
			default: cp = $urandom_range('h10000, 'h10FFFF);
		endcase
		return cp;
	endfunction

	// Appends cp in an n-byte form, which may be longer than needed.
	task automatic put_encoded(input int cp, input int n);
		int lead_mark;
		int lead_mask;
		lead_mark = (n == 2) ? 'hC0 : (n == 3) ? 'hE0 : 'hF0;
		lead_mask = (n == 2) ? 'h1F : (n == 3) ? 'h0F : 'h07;
		if (n == 1) begin
			append_octet(octet_t'(cp & 'h7F));
		end else begin
			append_octet(octet_t'(lead_mark | ((cp >> (6 * (n - 1))) & lead_mask)));
			for (int k = 1; k < n; k++)
				append_octet(octet_t'('h80 | ((cp >> (6 * (n - 1 - k))) & 'h3F)));
		end
	endtask

	task automatic put_char(input char_kind_t kind);
		int n;
		int pos;
		octet_t b;
		n = $urandom_range(2, 4);
		case (kind)
			CH_VALID: begin
				n = $urandom_range(1, 4);
				put_encoded(valid_code_point(n), n);
			end
			CH_NUL: append_octet(8'h00);
			CH_LEAD: begin
				if ($urandom_range(1) == 1)
					append_octet(octet_t'($urandom_range('h80, 'hBF)));
				else
					append_octet(octet_t'($urandom_range('hF8, 'hFF)));
			end
			CH_CONT: begin
				put_encoded(valid_code_point(n), n);
				pos = text.size() - $urandom_range(1, n - 1);
				b = octet_t'($urandom_range(255));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				text[pos] = b;
			end
			CH_OVERLONG: begin
				// Two-byte forms below 0x40 start with 0xC0, the rest with 0xC1.
				put_encoded($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF), n);
			end
			CH_SURR: put_encoded($urandom_range('hD800, 'hDFFF), 3);
			CH_ABOVE: put_encoded($urandom_range('h110000, 'h1FFFFF), 4);
			default: begin
				put_encoded(valid_code_point(n), n);
				for (int k = $urandom_range(1, n - 1); k > 0; k--)
					void'(text.pop_back());
			end
		endcase
	endtask

	initial begin
		int random_bytes;
		int nchar;
		int bad_at;
		int r;
		bit drained_once;
		random_bytes = 0;
		drained_once = 1'b0;

		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: each fault kind, a sequence ending on the final byte,
		// special leads, and a bad continuation inside a cut-off sequence.
		send_packed(32'h41, 1);
		send_packed(32'h00, 1);
		send_packed(32'hC280, 2);
		send_packed(32'hC080, 2);
		send_packed(32'hC1BF, 2);
		send_packed(32'hE08080, 3);
		send_packed(32'hEDA080, 3);
		send_packed(32'hF4908080, 4);
		send_packed(32'hF5808080, 4);
		send_packed(32'hE282, 2);
		send_packed(32'hE241, 2);
		send_packed(32'hFF, 1);
		wait_drained();

		while (random_bytes < RANDOM_BYTES) begin
			// A stretch of strings goes through with no idling on either side.
			if (random_bytes >= 200 && random_bytes < 400) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = 19;
				stall_pct = 19;
			end
			text.delete();
			r = $urandom_range(99);
			nchar = $urandom_range(1, 6);
			if (r < 15) begin
				repeat (nchar)
					append_octet(octet_t'($urandom_range(255)));
			end else begin
				bad_at = (r < 55) ? -1 : $urandom_range(0, nchar - 1);
				for (int i = 0; i < nchar; i++) begin
					if (i == bad_at)
						put_char(char_kind_t'($urandom_range(CH_NUL, CH_TRUNC)));
					else
						put_char(CH_VALID);
				end
			end
			send_text();
			random_bytes += text.size();
			if (!drained_once && random_bytes >= RANDOM_BYTES / 2) begin
				drained_once = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ utf8_stream_validator_top.f @@
+incdir+rtl/core
rtl/core/utf8sv_pkg.sv
rtl/core/utf8sv_step.sv
rtl/core/utf8_stream_validator_top.sv
bench/utf8_verdict_checker.sv
bench/tb_utf8_stream_validator_top.sv
